FILE: rtl/core/xcau_pkg.sv
// ----------------------------------------------------------------------------
// xcau_pkg
// Shared types and constants for the E8 call-address untranslate block.
// ----------------------------------------------------------------------------
package xcau_pkg;

	localparam int          TAIL_BYTES   = 10;
	localparam int          FILL_W       = 4;
	localparam int          OPERAND_BYTES = 4;
	localparam logic [7:0]  CALL_OPCODE  = 8'hE8;
	localparam logic [2:0]  SKIP_OPERAND = 3'd4;
	localparam logic [31:0] OFF_LIMIT    = 32'h4000_0000;

	// per-stage control of the delay line
	typedef struct packed {
		logic shift;  // take the neighbor's byte
		logic ins;    // load the incoming byte
		logic rw;     // load a rewritten operand byte
	} cell_ctl_t;

	typedef enum logic [1:0] {
		MODE_RUN,
		MODE_FLUSH,
		MODE_PRE_FLUSH
	} mode_t;

endpackage

FILE: rtl/core/xcau_cell.sv
// ----------------------------------------------------------------------------
// xcau_cell
// One byte stage of the delay line; shifts toward the output end.
// ----------------------------------------------------------------------------
module xcau_cell
	import xcau_pkg::*;
(
	input  logic       clk,
	input  cell_ctl_t  ctl,
	input  logic [7:0] next_byte,  // from the younger neighbor
	input  logic [7:0] ins_byte,
	input  logic [7:0] rw_byte,
	output logic [7:0] byte_q
);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			byte_q <= ins_byte;
		end else if (ctl.rw) begin
			byte_q <= rw_byte;
		end else if (ctl.shift) begin
			byte_q <= next_byte;
		end
	end

endmodule

FILE: rtl/core/xcau_xlat.sv
// ----------------------------------------------------------------------------
// xcau_xlat
// Operand translation: absolute call target back to relative displacement.
// ----------------------------------------------------------------------------
module xcau_xlat
	import xcau_pkg::*;
(
	input  logic [31:0] operand,
	input  logic [31:0] position,
	input  logic [31:0] xlat_size,
	output logic        hit,
	output logic [31:0] value
);

	logic below;
	logic above;

	assign below = operand < xlat_size;
	assign above = operand > ~position;
	assign hit   = below || above;
	assign value = below ? (operand - position) : (operand + xlat_size);

endmodule

FILE: rtl/core/x86_call_address_untranslate.sv
// ----------------------------------------------------------------------------
// x86_call_address_untranslate
// Undoes the E8 call-address translation on a decompressed byte stream.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while a chunk streams and the output is not
//   stalled; a chunk end adds a flush of up to 10 held bytes with input stalled.
// A byte enters the output register when the 10th later byte of its chunk is
//   accepted, or when a flush drains it; set by the 10-stage delay line.
// Stream start inside an unfinished chunk costs a flush of the held bytes.
// Reset (arst_n low) clears position, fill, skip, filter-off, size, output.
// ----------------------------------------------------------------------------
module x86_call_address_untranslate
	import xcau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration: translation size
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // chunk_end
	input  logic        s_tuser,   // stream_start
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast    // chunk_last
);

	// state
	mode_t             mode_q, mode_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [31:0]       pos_q, pos_d;       // position of the oldest held byte
	logic [2:0]        skip_q, skip_d;     // operand bytes left unscanned
	logic              off_q, off_d;
	logic [31:0]       tsize_q;
	logic [7:0]        pend_byte_q;        // byte parked during pre-flush
	logic              pend_last_q;
	logic              pend_load;

	// output register
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;

	// delay line
	logic [7:0]        cell_byte [TAIL_BYTES];
	cell_ctl_t         cell_ctl  [TAIL_BYTES];
	logic              shift_en;
	logic              ins_en;
	logic [FILL_W-1:0] ins_idx;
	logic [7:0]        ins_byte;
	logic              rw_en;

	// translation
	logic [31:0]       operand;
	logic              xl_hit;
	logic [31:0]       xl_value;

	// handshake
	logic              advance;
	logic              accept;
	logic              emit;
	logic              emit_last;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = advance && (mode_q == MODE_RUN);
	assign accept   = s_tvalid && s_tready;

	assign operand = {cell_byte[4], cell_byte[3], cell_byte[2], cell_byte[1]};

	xcau_xlat u_xlat (
		.operand    (operand),
		.position   (pos_q),
		.xlat_size  (tsize_q),
		.hit        (xl_hit),
		.value      (xl_value)
	);

	// next state and delay-line control
	always_comb begin
		mode_d    = mode_q;
		fill_d    = fill_q;
		pos_d     = pos_q;
		skip_d    = skip_q;
		off_d     = off_q;
		pend_load = 1'b0;
		emit      = 1'b0;
		emit_last = 1'b0;
		shift_en  = 1'b0;
		ins_en    = 1'b0;
		ins_idx   = fill_q;
		ins_byte  = s_tdata;
		rw_en     = 1'b0;
		unique case (mode_q)
			MODE_RUN: begin
				if (accept) begin
					if (s_tuser && fill_q != '0) begin
						// unfinished chunk: drain it before taking the byte
						pend_load = 1'b1;
						mode_d    = MODE_PRE_FLUSH;
					end else begin
						if (s_tuser) begin
							pos_d  = '0;
							off_d  = 1'b0;
							skip_d = '0;
						end
						if (fill_q == FILL_W'(TAIL_BYTES)) begin
							// line full: oldest byte leaves, scanned first
							emit     = 1'b1;
							shift_en = 1'b1;
							pos_d    = pos_q + 32'd1;
							ins_idx  = FILL_W'(TAIL_BYTES - 1);
							if (skip_q != '0) begin
								skip_d = skip_q - 3'd1;
							end else if (cell_byte[0] == CALL_OPCODE &&
								     tsize_q != '0 && !off_q) begin
								skip_d = SKIP_OPERAND;
								rw_en  = xl_hit;
							end
						end else begin
							fill_d = fill_q + FILL_W'(1);
						end
						ins_en = 1'b1;
						if (s_tlast) begin
							mode_d = MODE_FLUSH;
						end
					end
				end
			end
			MODE_FLUSH: begin
				if (advance) begin
					emit      = 1'b1;
					emit_last = (fill_q == FILL_W'(1));
					shift_en  = 1'b1;
					fill_d    = fill_q - FILL_W'(1);
					pos_d     = pos_q + 32'd1;
					if (emit_last) begin
						mode_d = MODE_RUN;
						skip_d = '0;
						off_d  = off_q || (pos_d >= OFF_LIMIT);
					end
				end
			end
			MODE_PRE_FLUSH: begin
				if (advance) begin
					emit      = 1'b1;
					emit_last = (fill_q == FILL_W'(1));
					shift_en  = 1'b1;
					fill_d    = fill_q - FILL_W'(1);
					pos_d     = pos_q + 32'd1;
					if (emit_last) begin
						// new stream begins with the parked byte
						pos_d    = '0;
						off_d    = 1'b0;
						skip_d   = '0;
						ins_en   = 1'b1;
						ins_idx  = '0;
						ins_byte = pend_byte_q;
						fill_d   = FILL_W'(1);
						mode_d   = pend_last_q ? MODE_FLUSH : MODE_RUN;
					end
				end
			end
			default: begin
				mode_d = MODE_RUN;
			end
		endcase
	end

	// delay line as a chain of stages, oldest at index 0
	for (genvar i = 0; i < TAIL_BYTES; i++) begin : g_line
		logic [7:0] nb;
		logic [7:0] rb;
		if (i < TAIL_BYTES - 1) begin : g_mid
			assign nb = cell_byte[i+1];
		end else begin : g_end
			assign nb = 8'h00;
		end
		// rewritten operand lands one stage older than its source
		if (i < OPERAND_BYTES) begin : g_op
			assign rb = xl_value[8*i +: 8];
		end else begin : g_nop
			assign rb = 8'h00;
		end
		assign cell_ctl[i].shift = shift_en;
		assign cell_ctl[i].ins   = ins_en && (ins_idx == FILL_W'(i));
		assign cell_ctl[i].rw    = rw_en && (i < OPERAND_BYTES);

		xcau_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[i]),
			.next_byte (nb),
			.ins_byte  (ins_byte),
			.rw_byte   (rb),
			.byte_q    (cell_byte[i])
		);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_RUN;
			fill_q      <= '0;
			pos_q       <= '0;
			skip_q      <= '0;
			off_q       <= 1'b0;
			tsize_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			fill_q <= fill_d;
			pos_q  <= pos_d;
			skip_q <= skip_d;
			off_q  <= off_d;
			if (cfg_we) begin
				tsize_q <= cfg_wdata;
			end
			if (advance) begin
				out_valid_q <= emit;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_byte_q <= s_tdata;
			pend_last_q <= s_tlast;
		end
		if (advance && emit) begin
			out_byte_q <= cell_byte[0];
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(TAIL_BYTES))
		else $error("delay line overfilled");

	a_skip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q <= SKIP_OPERAND)
		else $error("operand skip count out of range");

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_RUN |-> fill_q != '0)
		else $error("flush with empty delay line");

	a_flush_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_RUN |-> !s_tready)
		else $error("input taken during flush");

	a_last_ends_flush: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && emit_last |=> fill_q == '0 || fill_q == FILL_W'(1))
		else $error("chunk end flush left bytes behind");

endmodule

FILE: verif/xcau_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xcau_stream_checker
// Watches both stream ports and the size register, predicts the untranslated
// byte stream and compares every output transaction with it.
// ----------------------------------------------------------------------------
module xcau_stream_checker
	import xcau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // chunk_end
	input  logic        s_tuser,   // stream_start
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [7:0] out_byte
	input  logic        m_tlast,   // chunk_last
	output int unsigned fail_count,
	output int unsigned bytes_due,
	output int unsigned bytes_in,
	output int unsigned bytes_out,
	output int unsigned operands_rewritten
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_beat_t;

	out_beat_t   beats_q[$];
	logic [7:0]  held[TAIL_BYTES];
	int unsigned held_cnt     = 0;
	logic [31:0] position     = '0;   // stream position of the oldest held byte
	logic [2:0]  operand_skip = '0;
	logic        conv_off     = 1'b0;
	logic [31:0] xlat_size    = '0;

	function automatic void emit_beat(input logic [7:0] b, input logic last);
		beats_q.push_back('{data: b, last: last});
		position = position + 32'd1;
	endfunction

	function automatic void flush_held();
		for (int i = 0; i < held_cnt; i++)
			emit_beat(held[i], (i + 1) == held_cnt);
		held_cnt = 0;
		operand_skip = '0;
	endfunction

	// scan the oldest held byte; rewrites the operand behind a call opcode
	function automatic void untranslate_oldest();
		logic [31:0] operand;
		if (operand_skip != '0) begin
			operand_skip = operand_skip - 3'd1;
			return;
		end
		if (held[0] != CALL_OPCODE || xlat_size == '0 || conv_off)
			return;
		operand = {held[4], held[3], held[2], held[1]};
		operand_skip = SKIP_OPERAND;
		if (operand < xlat_size)
			operand = operand - position;
		else if (operand > ~position)
			operand = operand + xlat_size;
		else
			return;
		held[1] = operand[7:0];
		held[2] = operand[15:8];
		held[3] = operand[23:16];
		held[4] = operand[31:24];
		operands_rewritten++;
	endfunction

	function automatic void predict_byte(input logic [7:0] b, input logic ce, input logic ss);
		if (ss) begin
			flush_held();
			position = '0;
			conv_off = 1'b0;
		end
		if (held_cnt >= TAIL_BYTES) begin
			untranslate_oldest();
			emit_beat(held[0], 1'b0);
			for (int i = 1; i < TAIL_BYTES; i++)
				held[i - 1] = held[i];
			held_cnt = TAIL_BYTES - 1;
		end
		held[held_cnt] = b;
		held_cnt++;
		if (ce) begin
			flush_held();
			if (position >= OFF_LIMIT)
				conv_off = 1'b1;
		end
	endfunction

	// inputs change only at the rising edge, so the values seen here are the
	// ones the next rising edge acts on
	always @(negedge clk) begin
		out_beat_t want;
		if (!arst_n) begin
			beats_q.delete();
			held_cnt = 0;
			position = '0;
			operand_skip = '0;
			conv_off = 1'b0;
			xlat_size = '0;
			fail_count = 0;
			bytes_in = 0;
			bytes_out = 0;
			operands_rewritten = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				bytes_out++;
				if (beats_q.size() == 0) begin
					$error("unexpected output transaction: out_byte %02h chunk_last %0b",
						m_tdata, m_tlast);
					fail_count++;
				end else begin
					want = beats_q.pop_front();
					if (m_tdata !== want.data) begin
						$error("out_byte mismatch: expected %02h, actual %02h",
							want.data, m_tdata);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("chunk_last mismatch: expected %0b, actual %0b",
							want.last, m_tlast);
						fail_count++;
					end
				end
			end
			if (cfg_we)
				xlat_size = cfg_wdata;
			if (s_tvalid && s_tready) begin
				bytes_in++;
				predict_byte(s_tdata, s_tlast, s_tuser);
			end
		end
		bytes_due = beats_q.size();
	end

endmodule

FILE: verif/x86_call_address_untranslate_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// x86_call_address_untranslate_tb
// Drives chunked byte streams with call opcodes and crafted operands into the
// untranslate block under several translation sizes and handshake idling
// patterns; the stream checker predicts and compares every output byte.
// ----------------------------------------------------------------------------
module x86_call_address_untranslate_tb;
	import xcau_pkg::*;

	localparam int unsigned CYCLE_LIMIT     = 300000;
	localparam int          RESET_CYCLES    = 11;
	localparam int          DRAIN_CYCLES    = 14;  // chunk-end flush drains at most 10 held bytes
	localparam int          BYTES_PER_PHASE = 30;

	// directed bytes, {data_byte, chunk_end, stream_start}
	localparam logic [9:0] DIRECTED[26] = '{
		{8'h00, 1'b0, 1'b1},                        // new stream, position 0
		{CALL_OPCODE, 1'b0, 1'b0},                  // operand below size: minus position
		{8'h10, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0},
		{8'h00, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0},
		{CALL_OPCODE, 1'b0, 1'b0},                  // operand near -1: plus size
		{8'hFE, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b0},
		{8'hFF, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b0},
		{CALL_OPCODE, 1'b0, 1'b0},                  // mid-range operand, left alone;
		{CALL_OPCODE, 1'b0, 1'b0},                  // its opcode-valued bytes are
		{CALL_OPCODE, 1'b0, 1'b0},                  // never scanned themselves
		{CALL_OPCODE, 1'b0, 1'b0},
		{CALL_OPCODE, 1'b0, 1'b0},
		{CALL_OPCODE, 1'b0, 1'b0},                  // chunk tail: passes unchanged
		{8'h00, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b0},
		{CALL_OPCODE, 1'b0, 1'b0},
		{8'h01, 1'b0, 1'b0}, {8'h02, 1'b1, 1'b0},   // chunk end
		{8'h11, 1'b0, 1'b0}, {8'h22, 1'b0, 1'b0},
		{8'h33, 1'b0, 1'b0},
		{CALL_OPCODE, 1'b1, 1'b1}                   // stream start mid-chunk, 1-byte chunk
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // [7:0] data_byte
	logic        s_tlast   = 1'b0; // chunk_end
	logic        s_tuser   = 1'b0; // stream_start
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;          // [7:0] out_byte
	logic        m_tlast;          // chunk_last

	int unsigned fail_count;
	int unsigned bytes_due;
	int unsigned bytes_in;
	int unsigned bytes_out;
	int unsigned operands_rewritten;

	int unsigned cycle_cnt     = 0;
	int          tx_gap_pct    = 19;  // sender idle chance per transaction, percent
	int          rx_gap_pct    = 48;  // receiver stall chance per cycle, percent
	int          size_settings = 0;
	logic [31:0] size_now      = '0;  // last translation size written

	x86_call_address_untranslate dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	xcau_stream_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.s_tvalid           (s_tvalid),
		.s_tready           (s_tready),
		.s_tdata            (s_tdata),
		.s_tlast            (s_tlast),
		.s_tuser            (s_tuser),
		.m_tvalid           (m_tvalid),
		.m_tready           (m_tready),
		.m_tdata            (m_tdata),
		.m_tlast            (m_tlast),
		.fail_count         (fail_count),
		.bytes_due          (bytes_due),
		.bytes_in           (bytes_in),
		.bytes_out          (bytes_out),
		.operands_rewritten (operands_rewritten)
	);

	always #4 clk = ~clk;

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_gap_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d output bytes still due", cycle_cnt,
				bytes_due);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// One input transaction. Idle cycles go before it; tvalid stays high
	// from one transaction into the next when no idle cycle is drawn.
	// tready is sampled at the falling edge, where it already holds the value
	// the next rising edge sees.
	task automatic send_byte(input logic [7:0] b, input logic ce, input logic ss);
		logic granted;
		while ($urandom_range(99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= ce;
		s_tuser  <= ss;
		do begin
			@(negedge clk);
			granted = s_tready;
			@(posedge clk);
		end while (!granted);
	endtask

	// Stop sending and wait for every predicted byte, then leave room for a
	// chunk-end flush that may still be running.
	task automatic drain();
		s_tvalid <= 1'b0;
		wait (bytes_due == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Size register is only touched with the block drained and the delay
	// line empty (every phase ends on a chunk end).
	task automatic write_size(input logic [31:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		size_now = value;
		size_settings++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random chunk: mostly call opcodes followed by crafted operands,
	// mixed with noise bytes. Stream starts land on chunk heads and, now and
	// then, in the middle of a chunk.
	task automatic send_random_chunk(inout int sent);
		int          len;
		int          i;
		int          pick;
		logic [31:0] operand;
		logic        ss;
		logic [7:0]  b;
		pick = $urandom_range(9);
		if (pick < 2)
			len = $urandom_range(1, 10);      // too short for any scan
		else if (pick < 9)
			len = $urandom_range(11, 40);
		else
			len = $urandom_range(41, 90);
		i = 0;
		while (i < len) begin
			ss = ($urandom_range(i == 0 ? 4 : 39) == 0);
			if (i + 5 <= len && $urandom_range(3) == 0) begin
				case ($urandom_range(4))
					0: operand = (size_now == '0) ? $urandom : $urandom % size_now;
					1: operand = 32'hFFFF_FFFF - $urandom_range(400);  // around -position
					2: operand = size_now + $urandom_range(2) - 1;      // size boundary
					3: operand = $urandom;
					default: operand = $urandom_range(400);
				endcase
				send_byte(CALL_OPCODE, 1'b0, ss);
				for (int k = 0; k < 4; k++)
					send_byte(operand[8*k +: 8], (i + 2 + k) == len, 1'b0);
				i += 5;
			end else begin
				b = ($urandom_range(7) == 0) ? CALL_OPCODE : 8'($urandom);
				send_byte(b, (i + 1) == len, ss);
				i++;
			end
		end
		sent += len;
	endtask

	initial begin
		int sent;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, small size so both rewrite directions show up
		write_size(32'h0000_1000);
		for (int i = 0; i < 26; i++)
			send_byte(DIRECTED[i][9:2], DIRECTED[i][1], DIRECTED[i][0]);

		// random phases; each one drains the block before its size write
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					tx_gap_pct = 19;
					rx_gap_pct = 48;
					write_size(32'hFFFF_FFFF);
				end
				1: begin
					tx_gap_pct = 48;
					rx_gap_pct = 19;
					write_size(32'h0000_0000);            // conversion off
				end
				2: begin
					tx_gap_pct = 0;
					rx_gap_pct = 0;
					write_size(32'h0000_0001);
				end
				default: begin
					write_size($urandom_range(2, 32'h00FF_FFFF));
				end
			endcase
			sent = 0;
			while (sent < BYTES_PER_PHASE)
				send_random_chunk(sent);
		end

		drain();
		$display("Run: %0d bytes in, %0d bytes out, %0d call operands rewritten",
			bytes_in, bytes_out, operands_rewritten);
		$display("Translation size written %0d times (zero, one, all ones and others)",
			size_settings);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
